### hw/rtl/u2u_pkg.sv
// Package for the UTF-8 to UCS-4 fullwidth decoder.
// Holds the input kinds, register indexes, result types and decode tables.
// No dependencies.
package u2u_pkg;

	localparam int CP_W    = 32;
	localparam int CNT_W   = 10;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_LAST = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [1:0] REG_MAX_CHARS  = 2'd0;
	localparam logic [1:0] REG_FULLWIDTH  = 2'd1;

	localparam logic [9:0]      MAX_CHARS_RST  = 10'd1023;
	localparam logic [CP_W-1:0] FW_SHIFT       = 32'h0000_FEE0;
	localparam logic [CP_W-1:0] IDEO_SPACE     = 32'h0000_3000;
	localparam logic [CP_W-1:0] ASCII_SPACE    = 32'h0000_0020;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic             is_terminator;
		logic [CNT_W-1:0] char_count;
		logic             truncated;
	} res_t;

	// Up to two results from one byte: a character, then a terminator.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic [2:0] lead_trailing(input logic [7:0] b);
		logic [2:0] t;
		if (b < 8'hC0)      t = 3'd0;
		else if (b < 8'hE0) t = 3'd1;
		else if (b < 8'hF0) t = 3'd2;
		else if (b < 8'hF8) t = 3'd3;
		else if (b < 8'hFC) t = 3'd4;
		else                t = 3'd5;
		return t;
	endfunction

	function automatic logic [CP_W-1:0] seq_offset(input logic [2:0] t);
		logic [CP_W-1:0] o;
		case (t)
			3'd1:    o = 32'h0000_3080;
			3'd2:    o = 32'h000e_2080;
			3'd3:    o = 32'h03c8_2080;
			3'd4:    o = 32'hfa08_2080;
			3'd5:    o = 32'h8208_2080;
			default: o = '0;
		endcase
		return o;
	endfunction

endpackage

### hw/rtl/u2u_decode.sv
// Input register and single-pass decode of one UTF-8 byte per cycle while the queue has room.
// Keeps the per-string state and produces up to two results. Uses u2u_pkg.
module u2u_decode (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              in_kind,
	input  logic [7:0]              in_byte,
	input  logic                    room,
	input  logic [u2u_pkg::CNT_W-1:0] limit,
	input  logic                    fw_en,
	output logic                    push_en,
	output u2u_pkg::push_t          push
);
	import u2u_pkg::*;

	logic             valid_s1;
	logic [1:0]       kind_s1;
	logic [7:0]       byte_s1;
	logic             advance;

	logic [CP_W-1:0]  acc_q;
	logic [2:0]       rem_q;
	logic [2:0]       trail_q;
	logic [CNT_W-1:0] cnt_q;
	logic             drop_q;

	logic             is_data, is_end, done, emit;
	logic [CP_W-1:0]  acc_d, cp;
	logic [2:0]       rem_d, trail_d;
	logic [CNT_W-1:0] cnt_d;
	logic             drop_d;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= in_kind;
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		is_data = (kind_s1 == KIND_DATA) || (kind_s1 == KIND_LAST);
		is_end  = (kind_s1 != KIND_DATA);
		acc_d   = acc_q;
		rem_d   = rem_q;
		trail_d = trail_q;
		if (is_data) begin
			if (rem_q == 3'd0) begin
				acc_d   = {24'd0, byte_s1};
				trail_d = lead_trailing(byte_s1);
				rem_d   = trail_d;
			end else begin
				acc_d = (acc_q << 6) + {24'd0, byte_s1};
				rem_d = rem_q - 3'd1;
			end
		end
		done = is_data && (rem_d == 3'd0);

		cp = acc_d - seq_offset(trail_d);
		if (fw_en) begin
			if (cp inside {[32'h21:32'h7E]}) cp = cp + FW_SHIFT;
			else if (cp == ASCII_SPACE)      cp = IDEO_SPACE;
		end

		emit   = done && (cnt_q < limit);
		cnt_d  = emit ? CNT_W'(cnt_q + 1'b1) : cnt_q;
		drop_d = drop_q || (done && !emit);
		if (done) begin
			acc_d   = '0;
			trail_d = 3'd0;
		end

		push.n    = {1'b0, emit} + {1'b0, is_end};
		push.r0   = '{code_point: cp, is_terminator: 1'b0, char_count: cnt_d, truncated: 1'b0};
		push.r1   = '{code_point: '0, is_terminator: 1'b1, char_count: cnt_d,
			truncated: drop_d};
		// Without a character, the terminator moves to the first slot.
		if (!emit) push.r0 = push.r1;
	end

	assign push_en = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			rem_q   <= '0;
			trail_q <= '0;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
		end else if (advance) begin
			if (is_end) begin
				acc_q   <= '0;
				rem_q   <= '0;
				trail_q <= '0;
				cnt_q   <= '0;
				drop_q  <= 1'b0;
			end else begin
				acc_q   <= acc_d;
				rem_q   <= rem_d;
				trail_q <= trail_d;
				cnt_q   <= cnt_d;
				drop_q  <= drop_d;
			end
		end
	end

endmodule

### hw/rtl/u2u_outq.sv
// Small result queue: takes up to two results per cycle, gives one per cycle while out_ready is high.
// Parts the decode stage from the output handshake. Uses u2u_pkg.
module u2u_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_en,
	input  u2u_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output u2u_pkg::res_t  out_res
);
	import u2u_pkg::*;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [1:0]        n_in;
	logic              pop;

	assign n_in      = push_en ? push.n : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem_q[rptr_q];
	// Room for a full pair of results.
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) mem_q[wptr_q] <= push.r0;
		if (n_in == 2'd2) mem_q[QPTR_W'(wptr_q + 1'b1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= QPTR_W'(wptr_q + n_in);
			if (pop) rptr_q <= QPTR_W'(rptr_q + 1'b1);
			cnt_q <= QCNT_W'(cnt_q + n_in - {{(QCNT_W-1){1'b0}}, pop});
		end
	end

endmodule

### hw/rtl/utf8_to_ucs4_fullwidth_decoder.sv
// UTF-8 to UCS-4 decoder with fullwidth mapping, one byte word per cycle while not stalled.
// An accepted byte goes into the input register, and its results then into the queue.
// Throughput: one byte per cycle while the queue has room for two words; a final byte
// completing a character gives two words, drained one per ready cycle from a 4-entry queue.
// Reset (arst_n, asynchronous): string state and queue cleared, max_chars = 1023,
// fullwidth_enable = 1.
module utf8_to_ucs4_fullwidth_decoder #(
	parameter int MAX_CAPACITY = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] code_point, [41:32] char_count, rest zero
	output logic        m_axis_tlast,   // is_terminator
	output logic [0:0]  m_axis_tuser,   // [0] truncated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import u2u_pkg::*;

	localparam logic [CNT_W-1:0] CAP_LIM =
		(MAX_CAPACITY < 1024) ? CNT_W'(MAX_CAPACITY) : '1;

	logic [CNT_W-1:0] max_chars_q;
	logic             fw_en_q;
	logic [CNT_W-1:0] limit;
	logic             room, push_en;
	push_t            push;
	res_t             out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RST;
			fw_en_q     <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_CHARS: max_chars_q <= cfg_data;
				REG_FULLWIDTH: fw_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign limit = (CAP_LIM < max_chars_q) ? CAP_LIM : max_chars_q;

	u2u_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_byte  (s_axis_tdata),
		.room     (room),
		.limit    (limit),
		.fw_en    (fw_en_q),
		.push_en  (push_en),
		.push     (push)
	);

	u2u_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (push_en),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.char_count, out_res.code_point};
	assign m_axis_tlast = out_res.is_terminator;
	assign m_axis_tuser = out_res.truncated;

endmodule

### sim/testbench.sv
// Testbench for the UTF-8 to UCS-4 fullwidth decoder: directed strings, then random strings
// with fixed and random register settings and random stalls, checked word by word against a predictor.
// Depends on hw/rtl/u2u_pkg.sv and hw/rtl/utf8_to_ucs4_fullwidth_decoder.sv.
`timescale 1ns / 100ps

module testbench;
	import u2u_pkg::*;

	localparam int         CAPACITY   = 1023;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd2;

	// Tracks the decoder's string state and holds the words it should produce.
	class ucs4_scoreboard;
		logic [9:0]  max_chars;
		logic        wide_ascii;
		logic [31:0] acc;
		logic [2:0]  remaining;
		logic [2:0]  trailing;
		logic [9:0]  emitted;
		logic        dropped;
		res_t        pending_words[$];
		int          errors;
		int          chars_seen;
		int          strings_seen;
		int          cut_strings;

		function new();
			max_chars    = 10'd1023;
			wide_ascii   = 1'b1;
			errors       = 0;
			chars_seen   = 0;
			strings_seen = 0;
			cut_strings  = 0;
			clear_string();
		endfunction

		function void clear_string();
			acc       = '0;
			remaining = '0;
			trailing  = '0;
			emitted   = '0;
			dropped   = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [9:0] val);
			case (idx)
				REG_MAX_CHARS: max_chars = val;
				REG_FULLWIDTH: wide_ascii = val[0];
				default: ;
			endcase
		endfunction

		function logic [2:0] trail_count(logic [7:0] b);
			casez (b)
				8'b0???_????, 8'b10??_????: return 3'd0;
				8'b110?_????:               return 3'd1;
				8'b1110_????:               return 3'd2;
				8'b1111_0???:               return 3'd3;
				8'b1111_10??:               return 3'd4;
				default:                    return 3'd5;
			endcase
		endfunction

		// Sum of the marker bits that a sequence of this length leaves in the accumulator.
		function logic [31:0] length_offset(logic [2:0] t);
			case (t)
				3'd1:    return 32'h0000_3080;
				3'd2:    return 32'h000e_2080;
				3'd3:    return 32'h03c8_2080;
				3'd4:    return 32'hfa08_2080;
				3'd5:    return 32'h8208_2080;
				default: return 32'h0;
			endcase
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		function void note_byte(logic [1:0] kind, logic [7:0] b);
			logic [31:0] cp;
			logic [9:0]  limit;
			res_t        w;
			limit = (max_chars < CAPACITY) ? max_chars : 10'(CAPACITY);
			if (kind == KIND_DATA || kind == KIND_LAST) begin
				if (remaining == 0) begin
					acc       = {24'h0, b};
					trailing  = trail_count(b);
					remaining = trailing;
				end else begin
					acc       = (acc << 6) + {24'h0, b};
					remaining = remaining - 3'd1;
				end
				if (remaining == 0) begin
					cp = acc - length_offset(trailing);
					if (wide_ascii) begin
						if (cp >= 32'h21 && cp <= 32'h7E)
							cp = cp + 32'h0000_FEE0;
						else if (cp == 32'h20)
							cp = 32'h0000_3000;
					end
					acc      = '0;
					trailing = '0;
					if (emitted < limit) begin
						emitted         = emitted + 10'd1;
						w.code_point    = cp;
						w.is_terminator = 1'b0;
						w.char_count    = emitted;
						w.truncated     = 1'b0;
						pending_words.push_back(w);
						chars_seen++;
					end else begin
						dropped = 1'b1;
					end
				end
			end
			if (kind != KIND_DATA) begin
				if (remaining != 0)
					cut_strings++;
				w.code_point    = '0;
				w.is_terminator = 1'b1;
				w.char_count    = emitted;
				w.truncated     = dropped;
				pending_words.push_back(w);
				strings_seen++;
				clear_string();
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(res_t got);
			res_t want;
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word cp=%h last=%b count=%0d trunc=%b",
					got.code_point, got.is_terminator, got.char_count, got.truncated));
			end else begin
				want = pending_words.pop_front();
				if (got.code_point !== want.code_point)
					report($sformatf("code_point %h, expected %h", got.code_point,
						want.code_point));
				if (got.is_terminator !== want.is_terminator)
					report($sformatf("tlast %b, expected %b", got.is_terminator,
						want.is_terminator));
				if (got.char_count !== want.char_count)
					report($sformatf("char_count %0d, expected %0d", got.char_count,
						want.char_count));
				if (got.truncated !== want.truncated)
					report($sformatf("truncated %b, expected %b", got.truncated,
						want.truncated));
			end
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [9:0]  cfg_data  = '0;

	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;
	logic        cfg_ready;

	ucs4_scoreboard book;
	int          items_sent = 0;
	bit          tx_calm    = 1'b0;
	bit          rx_calm    = 1'b0;
	bit          rx_took    = 1'b0;
	int          rx_wait    = 0;

	utf8_to_ucs4_fullwidth_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Output side: a random stall after each accepted word, with calm stretches.
	always @(negedge clk) begin
		if (rx_took) begin
			rx_took = 1'b0;
			rx_wait = rx_calm ? 0 : $urandom_range(0, 16);
		end
		if ($urandom_range(0, 63) == 0)
			rx_calm = !rx_calm;
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && m_axis_tvalid && m_tready) begin
			got.code_point    = m_axis_tdata[31:0];
			got.char_count    = m_axis_tdata[41:32];
			got.is_terminator = m_axis_tlast;
			got.truncated     = m_axis_tuser[0];
			book.check_word(got);
			rx_took = 1'b1;
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		book.note_byte(kind, b);
		items_sent++;
		if ($urandom_range(0, 40) == 0)
			tx_calm = !tx_calm;
	endtask

	// Drains all expected words, then leaves room for a sequence still in flight.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (book.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		book.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] lead_byte(int len);
		case (len)
			0:       return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h20, 8'h7E))
			                                           : 8'($urandom_range(8'h00, 8'hBF));
			1:       return 8'($urandom_range(8'hC0, 8'hDF));
			2:       return 8'($urandom_range(8'hE0, 8'hEF));
			3:       return 8'($urandom_range(8'hF0, 8'hF7));
			4:       return 8'($urandom_range(8'hF8, 8'hFB));
			default: return 8'($urandom_range(8'hFC, 8'hFF));
		endcase
	endfunction

	// Mostly proper continuation bytes, now and then any byte at all.
	function automatic logic [7:0] trail_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	task automatic send_char(input bit closes);
		int len;
		int i;
		len = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 5);
		send_item((closes && len == 0) ? KIND_LAST : KIND_DATA, lead_byte(len));
		for (i = 1; i <= len; i++)
			send_item((closes && i == len) ? KIND_LAST : KIND_DATA, trail_byte());
	endtask

	task automatic send_string();
		int n;
		int style;
		int i;
		int len;
		int cut;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
		style = $urandom_range(0, 9);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(KIND_DATA, 8'($urandom_range(0, 255)));
			send_char(style <= 5 && i == n - 1);
		end
		if (style == 9) begin
			// End of string in the middle of a multi-byte sequence.
			len = $urandom_range(1, 5);
			cut = $urandom_range(0, len - 1);
			send_item(KIND_DATA, lead_byte(len));
			for (i = 0; i < cut; i++)
				send_item(KIND_DATA, trail_byte());
			if (cut + 1 < len && $urandom_range(0, 1) != 0)
				send_item(KIND_LAST, trail_byte());
			else
				send_item(($urandom_range(0, 1) != 0) ? KIND_END : KIND_SPARE,
					8'($urandom_range(0, 255)));
		end else if (style == 8) begin
			send_item(KIND_SPARE, 8'($urandom_range(0, 255)));
		end else if (style >= 6 || n == 0) begin
			send_item(KIND_END, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int phase;
		int target;
		book = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset settings: mapping edges, sequences of one, two, three and six bytes,
		// lead-looking trailing bytes, a cut-off sequence and both end kinds.
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'h20);
		send_item(KIND_DATA, 8'h21);
		send_item(KIND_DATA, 8'h7E);
		send_item(KIND_DATA, 8'h7F);
		send_item(KIND_DATA, 8'hC3);
		send_item(KIND_DATA, 8'hA9);
		send_item(KIND_DATA, 8'hE2);
		send_item(KIND_DATA, 8'h82);
		send_item(KIND_DATA, 8'hAC);
		send_item(KIND_DATA, 8'hFF);
		send_item(KIND_DATA, 8'hC0);
		send_item(KIND_DATA, 8'hBF);
		send_item(KIND_DATA, 8'h80);
		send_item(KIND_DATA, 8'hFF);
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_LAST, 8'h41);
		send_item(KIND_DATA, 8'hE2);
		send_item(KIND_DATA, 8'h82);
		send_item(KIND_END, 8'hFF);
		send_item(KIND_SPARE, 8'h00);

		// Limit lowered below the count of an open string.
		wait_idle();
		write_reg(REG_MAX_CHARS, 10'd3);
		send_item(KIND_DATA, 8'h41);
		send_item(KIND_DATA, 8'h42);
		wait_idle();
		write_reg(REG_MAX_CHARS, 10'd1);
		send_item(KIND_LAST, 8'h43);

		for (phase = 0; phase < 6; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					write_reg(REG_MAX_CHARS, 10'd0);
					write_reg(REG_FULLWIDTH, 10'h3FE);
				end
				1: begin
					write_reg(REG_MAX_CHARS, 10'd1023);
					write_reg(REG_FULLWIDTH, 10'h001);
					write_reg(REG_UNUSED, 10'($urandom_range(0, 1023)));
				end
				default: begin
					case ($urandom_range(0, 3))
						0:       write_reg(REG_MAX_CHARS, 10'($urandom_range(1, 6)));
						1:       write_reg(REG_MAX_CHARS, 10'($urandom_range(0, 1023)));
						2:       write_reg(REG_MAX_CHARS, 10'd1023);
						default: write_reg(REG_MAX_CHARS, 10'($urandom_range(0, 2)));
					endcase
					write_reg(REG_FULLWIDTH, 10'($urandom_range(0, 1023)));
				end
			endcase
			target = items_sent + 85;
			while (items_sent < target)
				send_string();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes in %0d strings (%0d ended inside a sequence).",
			items_sent, book.strings_seen, book.cut_strings);
		$display("Checked %0d characters over several limit and fullwidth settings.",
			book.chars_seen);
		if (book.errors == 0 && book.pending() == 0)
			$display("utf8_to_ucs4_fullwidth_decoder test passed");
		else
			$display("utf8_to_ucs4_fullwidth_decoder test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d words outstanding.", book.pending());
		$display("utf8_to_ucs4_fullwidth_decoder test failed");
		$finish;
	end

endmodule
